// ----- rtl/rgb555_color_histogram_core_macros.svh -----
// assertion macros for the rgb555 color histogram core
// no dependencies; included by the top level only
`ifndef RGB555_COLOR_HISTOGRAM_CORE_MACROS_SVH
`define RGB555_COLOR_HISTOGRAM_CORE_MACROS_SVH

// implication checked on every rising edge outside reset
`define RGBHIST_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never be true outside reset
`define RGBHIST_NEVER(name, clk, rst_n, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- rtl/rgbhist_pkg.sv -----
// shared types, constants and helpers of the rgb555 color histogram
// no dependencies; imported by the core, the clear sequencer and the testbench
package rgbhist_pkg;

  // bin store geometry, bin count is a power of two
  localparam int unsigned BIN_AW           = 15;
  localparam int unsigned NUM_BINS         = 1 << BIN_AW;
  localparam int unsigned BITS_PER_CHANNEL = 5;
  localparam int unsigned PIX_W            = 3 * BITS_PER_CHANNEL;

  // field widths of the stream items
  localparam int unsigned CNT_W     = 32;
  localparam int unsigned CHAN_W    = 8;
  localparam int unsigned BIDX_W    = 15;
  localparam int unsigned KIND_W    = 2;
  localparam int unsigned IN_DATA_W = 40;
  localparam int unsigned OUT_DATA_W = 64;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // item kinds carried in tuser
  typedef enum logic [KIND_W-1:0] {
    KIND_ACC   = 2'd0,
    KIND_READ  = 2'd1,
    KIND_CLEAR = 2'd2
  } kind_e;

  // clear sequencer status towards the core
  typedef struct packed {
    logic              busy;
    logic [BIN_AW-1:0] addr;
  } clr_t;

  // saturating increment
  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? v : v + CNT_W'(1);
  endfunction

  // bin of a pixel: top bits of each channel, red highest, modulo the bin count
  function automatic logic [BIN_AW-1:0] bin_of_pixel(input logic [CHAN_W-1:0] r,
                                                     input logic [CHAN_W-1:0] g,
                                                     input logic [CHAN_W-1:0] b);
    logic [PIX_W-1:0] packed_idx;
    logic [31:0]      wide;
    packed_idx = {r[CHAN_W-1 -: BITS_PER_CHANNEL], g[CHAN_W-1 -: BITS_PER_CHANNEL],
                  b[CHAN_W-1 -: BITS_PER_CHANNEL]};
    wide = 32'(packed_idx);
    return wide[BIN_AW-1:0];
  endfunction

  // requested bin index modulo the bin count
  function automatic logic [BIN_AW-1:0] bin_of_index(input logic [BIDX_W-1:0] idx);
    logic [31:0] wide;
    wide = 32'(idx);
    return wide[BIN_AW-1:0];
  endfunction

endpackage

// ----- rtl/rgb555_color_histogram_core.sv -----
// rgb555 color histogram: 32768 saturating 32-bit bins in one ram plus a pixel counter.
// Takes one item per cycle unless a clear sweep runs or a read is held: an accumulate reads its
// bin on acceptance and writes the incremented count back the next cycle, with a forwarding
// register covering back-to-back hits on one bin, so pixels stream at one per clock. A read item
// passes the stage and lands in an output register that drives tvalid; the read holds the input
// only while that register is full and not being taken. A clear item, and reset, start a sweep
// that zeroes every bin at one per cycle; tready stays low while the sweep runs and while the
// clear item sits in the stage.
// Depends on rgbhist_pkg, rgbhist_ram, rgbhist_clr and the macros header.
`include "rgb555_color_histogram_core_macros.svh"

module rgb555_color_histogram_core
  import rgbhist_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // blue[7:0] green[15:8] red[23:16] bin_index[38:24]
  input  logic [KIND_W-1:0]     s_axis_tuser,  // kind[1:0]
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata   // bin_count[31:0] pixel_total[63:32]
);

  // input field split
  logic [CHAN_W-1:0] in_blue, in_green, in_red;
  logic [BIDX_W-1:0] in_bidx;
  kind_e             in_kind;
  logic [BIN_AW-1:0] in_idx;

  assign in_blue  = s_axis_tdata[CHAN_W-1:0];
  assign in_green = s_axis_tdata[2*CHAN_W-1:CHAN_W];
  assign in_red   = s_axis_tdata[3*CHAN_W-1:2*CHAN_W];
  assign in_bidx  = s_axis_tdata[3*CHAN_W+BIDX_W-1:3*CHAN_W];
  assign in_kind  = kind_e'(s_axis_tuser);
  assign in_idx   = (in_kind == KIND_READ) ? bin_of_index(in_bidx)
                                           : bin_of_pixel(in_red, in_green, in_blue);

  // pipeline and result registers
  logic              s1_vld_q, s1_vld_d;
  kind_e             s1_kind_q;
  logic [BIN_AW-1:0] s1_idx_q;
  logic              fwd_hit_q;
  logic [CNT_W-1:0]  fwd_data_q;
  logic [CNT_W-1:0]  pix_q, pix_d;
  logic              out_vld_q, out_vld_d;
  logic [CNT_W-1:0]  out_bin_q, out_tot_q;

  clr_t              clr;
  logic [CNT_W-1:0]  rd_data;
  logic [CNT_W-1:0]  cur_cnt, inc_cnt;
  logic              s1_is_acc, s1_is_read, s1_is_clr, s1_adv;
  logic              out_free, accept, acc_wr;
  logic              ram_we;
  logic [BIN_AW-1:0] ram_waddr;
  logic [CNT_W-1:0]  ram_wdata;

  // stage decode
  always_comb begin
    s1_is_acc  = 1'b0;
    s1_is_read = 1'b0;
    s1_is_clr  = 1'b0;
    unique case (s1_kind_q)
      KIND_ACC:   s1_is_acc  = s1_vld_q;
      KIND_READ:  s1_is_read = s1_vld_q;
      KIND_CLEAR: s1_is_clr  = s1_vld_q;
      default: ;
    endcase
  end

  // read-modify-write datapath with forwarding of the previous write
  assign cur_cnt = fwd_hit_q ? fwd_data_q : rd_data;
  assign inc_cnt = sat_inc(cur_cnt);
  assign acc_wr  = s1_is_acc;

  // handshake: a read holds the stage only while the output register is full and not being taken
  assign out_free      = !out_vld_q || m_axis_tready;
  assign s1_adv        = s1_vld_q && (!s1_is_read || out_free);
  assign s_axis_tready = !clr.busy && !s1_is_clr && (!s1_vld_q || s1_adv);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // ram write port: clear sweep or bin write-back
  always_comb begin
    ram_we    = clr.busy || acc_wr;
    ram_waddr = clr.busy ? clr.addr : s1_idx_q;
    ram_wdata = clr.busy ? '0 : inc_cnt;
  end

  rgbhist_ram #(
    .DEPTH (NUM_BINS),
    .WIDTH (CNT_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (accept),
    .raddr_i (in_idx),
    .rdata_o (rd_data)
  );

  rgbhist_clr u_clr (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (s1_is_clr),
    .clr_o   (clr)
  );

  // next state of control
  always_comb begin
    s1_vld_d = s1_vld_q;
    if (accept) begin
      s1_vld_d = 1'b1;
    end else if (s1_adv) begin
      s1_vld_d = 1'b0;
    end

    pix_d = pix_q;
    if (acc_wr) begin
      pix_d = sat_inc(pix_q);
    end else if (s1_is_clr) begin
      pix_d = '0;
    end

    out_vld_d = out_vld_q;
    if (s1_is_read && s1_adv) begin
      out_vld_d = 1'b1;
    end else if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      pix_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      s1_vld_q  <= s1_vld_d;
      pix_q     <= pix_d;
      out_vld_q <= out_vld_d;
    end
  end

  // stage payload, forward when the item hits the bin being written this cycle
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_kind_q  <= in_kind;
      s1_idx_q   <= in_idx;
      fwd_hit_q  <= acc_wr && (s1_idx_q == in_idx);
      fwd_data_q <= inc_cnt;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (s1_is_read && s1_adv) begin
      out_bin_q <= cur_cnt;
      out_tot_q <= pix_q;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {out_tot_q, out_bin_q};

  // checks
  `RGBHIST_ASSERT(a_no_accept_in_clear, clk_i, rst_ni, clr.busy |-> !s_axis_tready, "accept in clear")
  `RGBHIST_NEVER(a_write_conflict, clk_i, rst_ni, clr.busy && acc_wr, "write-back in clear")
  `RGBHIST_ASSERT(a_read_stall, clk_i, rst_ni, (s1_is_read && !s1_adv) |-> (out_vld_q && !m_axis_tready), "bad stall")
  `RGBHIST_ASSERT(a_result_source, clk_i, rst_ni, $rose(out_vld_q) |-> $past(s1_is_read), "stray result")

endmodule

// ----- rtl/rgbhist_ram.sv -----
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module rgbhist_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 32,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read port, old data on a same-cycle write
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/rgbhist_clr.sv -----
// clear sequencer, sweeps every bin once after reset and on request
// depends on rgbhist_pkg
module rgbhist_clr
  import rgbhist_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  output clr_t clr_o
);

  logic              busy_q, busy_d;
  logic [BIN_AW-1:0] cnt_q, cnt_d;

  // sweep counter
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
    end else if (busy_q) begin
      cnt_d = cnt_q + BIN_AW'(1);
      if (cnt_q == BIN_AW'(NUM_BINS - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  // sweep starts right out of reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  assign clr_o.busy = busy_q;
  assign clr_o.addr = cnt_q;

endmodule

// ----- tb/sv/tb.sv -----
// self-checking testbench of rgb555_color_histogram_core: pixel streams, bin reads and clears
// checked against an in-bench histogram predictor; uses rgbhist_pkg and the core rtl only
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rgbhist_pkg::*;

  // kind code that the core must ignore
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  // reset sweep plus up to seven clear sweeps, then a wide margin
  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int unsigned RANDOM_ITEMS = 500;
  localparam int unsigned MAX_RANDOM_CLEARS = 6;
  localparam int unsigned PALETTE_SIZE = 6;

  typedef struct packed {
    logic [CNT_W-1:0] pixel_total;
    logic [CNT_W-1:0] bin_count;
  } bin_report_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;   // blue[7:0] green[15:8] red[23:16] bin_index[38:24]
  logic [KIND_W-1:0]     s_axis_tuser = '0;   // kind[1:0]
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;        // bin_count[31:0] pixel_total[63:32]

  // predictor state
  logic [CNT_W-1:0] hist_model [NUM_BINS];
  logic [CNT_W-1:0] pixel_model;
  bin_report_t      report_q [$];

  int unsigned cycle_cnt = 0;
  int unsigned error_cnt = 0;
  int unsigned src_idle_pct = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned sink_hold_cycles = 0;
  int unsigned clears_left = MAX_RANDOM_CLEARS;

  rgb555_color_histogram_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // receiver: random stalls, or a counted hold-off when one is requested
  initial begin
    forever begin
      @(negedge clk_i);
      if (sink_hold_cycles != 0) begin
        m_axis_tready <= 1'b0;
        sink_hold_cycles--;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  // result checker, oldest expected report first
  always @(posedge clk_i) begin
    bin_report_t exp_rep;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (report_q.size() == 0) begin
        $display("[%0t] unexpected result transfer, got bin_count %0d pixel_total %0d",
                 $time, m_axis_tdata[31:0], m_axis_tdata[63:32]);
        error_cnt++;
      end else begin
        exp_rep = report_q.pop_front();
        if (m_axis_tdata[31:0] !== exp_rep.bin_count) begin
          $display("[%0t] bin_count mismatch: expected %0d, actual %0d",
                   $time, exp_rep.bin_count, m_axis_tdata[31:0]);
          error_cnt++;
        end
        if (m_axis_tdata[63:32] !== exp_rep.pixel_total) begin
          $display("[%0t] pixel_total mismatch: expected %0d, actual %0d",
                   $time, exp_rep.pixel_total, m_axis_tdata[63:32]);
          error_cnt++;
        end
      end
    end
  end

  // counter increment that holds at all ones
  function automatic logic [CNT_W-1:0] count_up(input logic [CNT_W-1:0] c);
    return (c == {CNT_W{1'b1}}) ? c : c + CNT_W'(1);
  endfunction

  function automatic void histogram_clear();
    foreach (hist_model[i]) hist_model[i] = '0;
    pixel_model = '0;
  endfunction

  // histogram predictor, applied to each accepted item
  function automatic void histogram_update(input logic [KIND_W-1:0] kind,
                                           input logic [CHAN_W-1:0] red, green, blue,
                                           input logic [BIDX_W-1:0] bin_idx);
    logic [BIN_AW-1:0] pix_bin;
    bin_report_t       rep;
    pix_bin = {red[7:8-BITS_PER_CHANNEL], green[7:8-BITS_PER_CHANNEL],
               blue[7:8-BITS_PER_CHANNEL]};
    case (kind)
      KIND_ACC: begin
        hist_model[pix_bin] = count_up(hist_model[pix_bin]);
        pixel_model = count_up(pixel_model);
      end
      KIND_READ: begin
        rep.bin_count = hist_model[bin_idx[BIN_AW-1:0]];
        rep.pixel_total = pixel_model;
        report_q.push_back(rep);
      end
      KIND_CLEAR: histogram_clear();
      default: ;
    endcase
  endfunction

  // one input transfer; entered and left at a falling edge with tvalid still high
  task automatic send_item(input logic [KIND_W-1:0] kind,
                           input logic [CHAN_W-1:0] red, green, blue,
                           input logic [BIDX_W-1:0] bin_idx);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {1'b0, bin_idx, red, green, blue};
    do @(posedge clk_i); while (!s_axis_tready);
    histogram_update(kind, red, green, blue, bin_idx);
    @(negedge clk_i);
  endtask

  // sender pause until every expected read result has come back
  task automatic wait_reports_drained();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (report_q.size() != 0);
  endtask

  task automatic send_read(input logic [BIDX_W-1:0] bin_idx);
    send_item(KIND_READ, CHAN_W'($urandom), CHAN_W'($urandom), CHAN_W'($urandom), bin_idx);
  endtask

  task automatic send_pixel(input logic [CHAN_W-1:0] red, green, blue);
    send_item(KIND_ACC, red, green, blue, BIDX_W'($urandom));
  endtask

  // store and pixel count are zero after the reset sweep
  task automatic test_reset_state();
    send_item(KIND_READ, 8'h00, 8'h00, 8'h00, 15'h0000);
    send_item(KIND_READ, 8'hff, 8'hff, 8'hff, 15'h7fff);
  endtask

  // channel extremes, ignored low bits and back-to-back hits on one bin
  task automatic test_accumulate_bins();
    send_pixel(8'h00, 8'h00, 8'h00);
    send_pixel(8'hff, 8'hff, 8'hff);
    send_pixel(8'hff, 8'hff, 8'hff);
    send_pixel(8'hf8, 8'hf8, 8'hf8);
    send_read(15'h7fff);
    send_pixel(8'h07, 8'h07, 8'h07);
    send_read(15'h0000);
    send_pixel(8'h07, 8'hf8, 8'h00);
    send_read({5'd0, 5'd31, 5'd0});
    send_pixel(8'h80, 8'h3f, 8'hc7);
    send_read({5'd16, 5'd7, 5'd24});
  endtask

  // kind 3 with every field set changes nothing
  task automatic test_unused_kind();
    send_item(KIND_UNUSED, 8'hff, 8'hff, 8'hff, 15'h7fff);
    send_item(KIND_READ, 8'hff, 8'hff, 8'hff, 15'h7fff);
  endtask

  // clear zeroes bins and total, counting restarts right after
  task automatic test_clear();
    send_item(KIND_CLEAR, 8'hff, 8'hff, 8'hff, 15'h7fff);
    send_read(15'h7fff);
    send_read(15'h0000);
    send_pixel(8'hff, 8'hff, 8'hff);
    send_read(15'h7fff);
  endtask

  // long receiver hold-off while reads and pixels keep coming, so the input stalls
  task automatic test_output_stall();
    sink_hold_cycles = 200;
    send_read(15'h7fff);
    send_pixel(8'hff, 8'hff, 8'hff);
    send_read(15'h7fff);
    send_read(15'h0000);
    send_pixel(8'h00, 8'h00, 8'h00);
    send_read(15'h0000);
    wait_reports_drained();
  endtask

  // random items over a small palette so that reads hit populated bins
  task automatic run_random_phase(input int unsigned n_items, input int unsigned src_pct,
                                  input int unsigned sink_pct);
    logic [CHAN_W-1:0] pal_r [PALETTE_SIZE];
    logic [CHAN_W-1:0] pal_g [PALETTE_SIZE];
    logic [CHAN_W-1:0] pal_b [PALETTE_SIZE];
    int unsigned       roll;
    int unsigned       p;
    src_idle_pct = src_pct;
    sink_stall_pct = sink_pct;
    foreach (pal_r[i]) begin
      pal_r[i] = CHAN_W'($urandom);
      pal_g[i] = CHAN_W'($urandom);
      pal_b[i] = CHAN_W'($urandom);
    end
    for (int unsigned k = 0; k < n_items; k++) begin
      roll = $urandom_range(999);
      p = $urandom_range(PALETTE_SIZE - 1);
      if (roll < 3 && clears_left != 0) begin
        clears_left--;
        send_item(KIND_CLEAR, CHAN_W'($urandom), CHAN_W'($urandom), CHAN_W'($urandom),
                  BIDX_W'($urandom));
      end else if (roll < 30) begin
        send_item(KIND_UNUSED, CHAN_W'($urandom), CHAN_W'($urandom), CHAN_W'($urandom),
                  BIDX_W'($urandom));
      end else if (roll < 640) begin
        if ($urandom_range(3) != 0)
          send_pixel({pal_r[p][7:3], 3'($urandom)}, {pal_g[p][7:3], 3'($urandom)},
                     {pal_b[p][7:3], 3'($urandom)});
        else
          send_pixel(CHAN_W'($urandom), CHAN_W'($urandom), CHAN_W'($urandom));
      end else begin
        if ($urandom_range(9) < 7)
          send_read({pal_r[p][7:3], pal_g[p][7:3], pal_b[p][7:3]});
        else
          send_read(BIDX_W'($urandom));
      end
    end
    wait_reports_drained();
  endtask

  // four phases with varied source idling and sink stalls, each ending with a full drain
  task automatic test_random_traffic();
    run_random_phase(RANDOM_ITEMS, 0, 0);
    run_random_phase(RANDOM_ITEMS, 88, 0);
    run_random_phase(RANDOM_ITEMS, 0, 88);
    run_random_phase(RANDOM_ITEMS, 34, 34);
  endtask

  // reset, test sequence and final verdict
  initial begin
    histogram_clear();
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_reset_state();
    test_accumulate_bins();
    test_unused_kind();
    test_clear();
    test_output_stall();
    test_random_traffic();
    wait_reports_drained();
    repeat (20) @(negedge clk_i);
    if (error_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
